// ----- sv/sample_stream_segmenter_stats_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SAMPLE_STREAM_SEGMENTER_STATS_UNIT_MACROS_SVH
`define SAMPLE_STREAM_SEGMENTER_STATS_UNIT_MACROS_SVH

`define SSSU_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segmenter check failed");

`define SSSU_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segmenter check failed");

`endif

// ----- sv/sss_pkg.sv -----
package sss_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam logic [16:0] MAX_POINTS = 17'h10000;

    typedef enum logic [1:0] {
        MODE_WINDOW = 2'd0,
        MODE_JUMP   = 2'd1,
        MODE_GAP    = 2'd2,
        MODE_MARKER = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_WINDOW = 3'd1,
        REG_JUMP   = 3'd2,
        REG_GAP    = 3'd3,
        REG_MARKER = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV_MEAN,
        B_MUL_NUM,
        B_MUL_SQ,
        B_MUL_NN,
        B_DIV_VAR,
        B_ROOT,
        B_HOLD
    } back_state_t;

    typedef struct packed {
        logic [15:0]        first;
        logic [15:0]        last;
        logic [16:0]        count;
        logic signed [32:0] sum;
        logic [46:0]        sqsum;
        logic signed [15:0] low;
        logic signed [15:0] high;
        logic               done;
        logic               run_end;
    } seg_rec_t;

endpackage

// ----- sv/sample_stream_segmenter_stats_unit.sv -----
// Samples are taken one per cycle while the segment queue has room for two words.
// With the back end idle, a segment's word reaches the outputs once its closing sample
// is accepted and has passed two 64-step divisions, three shift-add multiplications
// that run for the bit length of their multiplier, and a 16-step square root.
// The back end takes a segment only once the last is at the outputs, which bounds the rate.
// Reset clears the configuration to its defaults and empties the open segment, the queue and the output.
module sample_stream_segmenter_stats_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] sample,
    input  logic               final_sample,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        seg_first,
    output logic [15:0]        seg_last,
    output logic signed [15:0] seg_mean,
    output logic [15:0]        seg_spread,
    output logic signed [15:0] seg_low,
    output logic signed [15:0] seg_high,
    output logic               run_end,
    output logic               set_done
);
    import sss_pkg::*;

    logic     wr0;
    logic     wr1;
    seg_rec_t rec0;
    seg_rec_t rec1;
    seg_rec_t q_data;
    logic     q_pop;
    logic     q_empty;
    logic     q_full;

    assign full = q_full;

    sss_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .sample       (sample),
        .final_sample (final_sample),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .wr0          (wr0),
        .wr1          (wr1),
        .rec0         (rec0),
        .rec1         (rec1)
    );

    sss_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr0     (wr0),
        .wr1     (wr1),
        .data0   (rec0),
        .data1   (rec1),
        .rd      (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    sss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .seg_first  (seg_first),
        .seg_last   (seg_last),
        .seg_mean   (seg_mean),
        .seg_spread (seg_spread),
        .seg_low    (seg_low),
        .seg_high   (seg_high),
        .run_end    (run_end),
        .set_done   (set_done)
    );

endmodule

// ----- sv/sss_queue.sv -----
module sss_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr0,
    input  logic              wr1,
    input  sss_pkg::seg_rec_t data0,
    input  sss_pkg::seg_rec_t data1,
    input  logic              rd,
    output sss_pkg::seg_rec_t rd_data,
    output logic              q_empty,
    output logic              q_full
);
    import sss_pkg::*;

    seg_rec_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     cnt_reg;
    logic [QPTR_W:0]     cnt_next;
    logic [QPTR_W:0]     n_wr;
    logic [QPTR_W-1:0]   wr_ptr_p1;

    assign n_wr      = (QPTR_W+1)'(wr0) + (QPTR_W+1)'(wr1);
    assign wr_ptr_p1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next = wr_ptr_reg + n_wr[QPTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + QPTR_W'(rd);
    assign cnt_next    = cnt_reg + n_wr - (QPTR_W+1)'(rd);
    assign rd_data     = mem_reg[rd_ptr_reg];
    assign q_empty     = (cnt_reg == '0);
    assign q_full      = (cnt_reg > (QPTR_W+1)'(QDEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            mem_reg[wr_ptr_reg] <= data0;
        end
        if (wr1)
        begin
            mem_reg[wr_ptr_p1] <= data1;
        end
    end

endmodule

// ----- sv/sss_front.sv -----
module sss_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic signed [15:0] sample,
    input  logic               final_sample,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               q_full,
    output logic               wr0,
    output logic               wr1,
    output sss_pkg::seg_rec_t  rec0,
    output sss_pkg::seg_rec_t  rec1
);
    import sss_pkg::*;

    mode_t              mode_reg;
    logic [16:0]        window_reg;
    logic [15:0]        jump_reg;
    logic [15:0]        gap_reg;
    logic signed [15:0] marker_reg;

    logic [15:0]        pos_reg;
    logic [15:0]        start_reg;
    logic signed [15:0] prior_reg;
    logic [16:0]        count_reg;
    logic signed [32:0] sum_reg;
    logic [46:0]        sqsum_reg;
    logic signed [15:0] low_reg;
    logic signed [15:0] high_reg;

    logic               accept;
    logic signed [16:0] diff;
    logic [16:0]        adiff;
    logic [15:0]        lim;
    logic               cut;
    logic [16:0]        base_count;
    logic signed [32:0] base_sum;
    logic [46:0]        base_sqsum;
    logic               drop;
    logic signed [16:0] s_ext;
    logic [16:0]        neg_s;
    logic [15:0]        mag;
    logic [31:0]        sq;
    logic [16:0]        new_count;
    logic signed [32:0] new_sum;
    logic [46:0]        new_sqsum;
    logic signed [15:0] new_low;
    logic signed [15:0] new_high;
    logic [15:0]        new_start;
    logic               close;
    logic [15:0]        prev_idx;
    seg_rec_t           open_rec;
    seg_rec_t           new_rec;

    assign accept = push && !q_full;

    assign s_ext  = 17'(sample);
    assign neg_s  = -s_ext;
    assign mag    = sample[15] ? neg_s[15:0] : sample;
    assign sq     = mag * mag;
    assign diff   = s_ext - 17'(prior_reg);
    assign adiff  = diff[16] ? 17'(-diff) : 17'(diff);
    assign lim    = (mode_reg == MODE_JUMP) ? jump_reg : gap_reg;
    assign cut    = (mode_reg == MODE_JUMP || mode_reg == MODE_GAP) && (count_reg != '0)
                    && (adiff > {1'b0, lim});

    assign base_count = cut ? '0 : count_reg;
    assign base_sum   = cut ? '0 : sum_reg;
    assign base_sqsum = cut ? '0 : sqsum_reg;
    assign drop       = (mode_reg == MODE_MARKER) && (sample == marker_reg)
                        && (base_count != '0);

    assign new_count = base_count + 17'd1;
    assign new_sum   = base_sum + 33'(sample);
    assign new_sqsum = base_sqsum + 47'(sq);
    assign new_low   = (base_count == '0 || sample < low_reg) ? sample : low_reg;
    assign new_high  = (base_count == '0 || sample > high_reg) ? sample : high_reg;
    assign new_start = (base_count == '0) ? pos_reg : start_reg;
    assign close     = final_sample || (new_count == MAX_POINTS)
                       || (mode_reg == MODE_WINDOW && new_count >= window_reg);
    assign prev_idx  = pos_reg - 16'd1;

    always_comb
    begin
        open_rec.first   = start_reg;
        open_rec.last    = prev_idx;
        open_rec.count   = count_reg;
        open_rec.sum     = sum_reg;
        open_rec.sqsum   = sqsum_reg;
        open_rec.low     = low_reg;
        open_rec.high    = high_reg;
        open_rec.done    = final_sample && !cut;
        open_rec.run_end = 1'b1;

        new_rec.first   = new_start;
        new_rec.last    = pos_reg;
        new_rec.count   = new_count;
        new_rec.sum     = new_sum;
        new_rec.sqsum   = new_sqsum;
        new_rec.low     = new_low;
        new_rec.high    = new_high;
        new_rec.done    = final_sample;
        new_rec.run_end = 1'b1;

        wr0  = accept && (cut || drop || close);
        wr1  = accept && cut && close;
        rec0 = (cut || drop) ? open_rec : new_rec;
        rec0.run_end = !(cut && close);
        rec1 = new_rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_WINDOW;
            window_reg <= 17'd100;
            jump_reg   <= 16'd3;
            gap_reg    <= 16'd100;
            marker_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= mode_t'(cfg_data[1:0]);
                REG_WINDOW: window_reg <= (cfg_data == '0) ? 17'd1 : cfg_data;
                REG_JUMP:   jump_reg   <= cfg_data[15:0];
                REG_GAP:    gap_reg    <= cfg_data[15:0];
                REG_MARKER: marker_reg <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            start_reg <= '0;
            prior_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
        end
        else if (accept)
        begin
            if (final_sample || drop || close)
            begin
                start_reg <= '0;
                count_reg <= '0;
                sum_reg   <= '0;
                sqsum_reg <= '0;
                low_reg   <= '0;
                high_reg  <= '0;
            end
            else
            begin
                start_reg <= new_start;
                count_reg <= new_count;
                sum_reg   <= new_sum;
                sqsum_reg <= new_sqsum;
                low_reg   <= new_low;
                high_reg  <= new_high;
            end
            if (final_sample)
            begin
                pos_reg   <= '0;
                prior_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_reg + 16'd1;
                prior_reg <= sample;
            end
        end
    end

endmodule

// ----- sv/sss_back.sv -----
module sss_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  sss_pkg::seg_rec_t  q_data,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [15:0]        seg_first,
    output logic [15:0]        seg_last,
    output logic signed [15:0] seg_mean,
    output logic [15:0]        seg_spread,
    output logic signed [15:0] seg_low,
    output logic signed [15:0] seg_high,
    output logic               run_end,
    output logic               set_done
);
    import sss_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    seg_rec_t    rec_reg;
    logic [64:0] rem_reg;
    logic [63:0] quo_reg;
    logic [64:0] den_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] mul_a_reg;
    logic [46:0] mul_b_reg;
    logic [63:0] acc_reg;
    logic [63:0] num_reg;
    logic [31:0] sx_reg;
    logic [31:0] sr_reg;
    logic [31:0] sbit_reg;
    logic [15:0] mean_reg;
    logic        out_valid_reg;
    logic        out_load;

    logic [64:0] rem_shift;
    logic        div_ge;
    logic [64:0] rem_step;
    logic [63:0] quo_step;
    logic [63:0] acc_step;
    logic        mul_done;
    logic [32:0] trial;
    logic        root_ge;
    logic [31:0] sx_step;
    logic [31:0] sr_step;
    logic [32:0] q_abs;
    logic [31:0] q_amag;
    logic [32:0] r_abs;
    logic [31:0] r_amag;
    logic [15:0] mean_val;

    assign rem_shift = {rem_reg[63:0], quo_reg[63]};
    assign div_ge    = (rem_shift >= den_reg);
    assign rem_step  = div_ge ? rem_shift - den_reg : rem_shift;
    assign quo_step  = {quo_reg[62:0], div_ge};

    assign acc_step = acc_reg + (mul_b_reg[0] ? mul_a_reg : 64'd0);
    assign mul_done = (mul_b_reg[46:1] == '0);

    assign trial   = {1'b0, sr_reg} + {1'b0, sbit_reg};
    assign root_ge = ({1'b0, sx_reg} >= trial);
    assign sx_step = root_ge ? sx_reg - trial[31:0] : sx_reg;
    assign sr_step = root_ge ? (sr_reg >> 1) + sbit_reg : (sr_reg >> 1);

    assign q_abs    = q_data.sum[32] ? 33'(-q_data.sum) : 33'(q_data.sum);
    assign q_amag   = q_abs[31:0];
    assign r_abs    = rec_reg.sum[32] ? 33'(-rec_reg.sum) : 33'(rec_reg.sum);
    assign r_amag   = r_abs[31:0];
    assign mean_val = rec_reg.sum[32] ? 16'(-quo_step[15:0]) : quo_step[15:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:     if (!q_empty) state_next = B_DIV_MEAN;
            B_DIV_MEAN: if (cnt_reg == '0) state_next = B_MUL_NUM;
            B_MUL_NUM:  if (mul_done) state_next = B_MUL_SQ;
            B_MUL_SQ:   if (mul_done) state_next = B_MUL_NN;
            B_MUL_NN:   if (mul_done) state_next = B_DIV_VAR;
            B_DIV_VAR:  if (cnt_reg == '0) state_next = B_ROOT;
            B_ROOT:     if (sbit_reg[0]) state_next = B_HOLD;
            B_HOLD:     if (!out_valid_reg) state_next = B_IDLE;
            default:    state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            B_IDLE:  q_pop    = !q_empty;
            B_HOLD:  out_load = !out_valid_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_load || (out_valid_reg && !pop);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                rec_reg <= q_data;
                rem_reg <= '0;
                quo_reg <= 64'(q_amag);
                den_reg <= 65'(q_data.count);
                cnt_reg <= '1;
            end
            B_DIV_MEAN:
            begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    mean_reg  <= mean_val;
                    mul_a_reg <= 64'(rec_reg.count);
                    mul_b_reg <= rec_reg.sqsum;
                    acc_reg   <= '0;
                end
            end
            B_MUL_NUM, B_MUL_SQ, B_MUL_NN:
            begin
                if (mul_done)
                begin
                    acc_reg <= '0;
                    if (state_reg == B_MUL_NUM)
                    begin
                        num_reg   <= acc_step;
                        mul_a_reg <= 64'(r_amag);
                        mul_b_reg <= 47'(r_amag);
                    end
                    else if (state_reg == B_MUL_SQ)
                    begin
                        quo_reg   <= (num_reg > acc_step) ? num_reg - acc_step : 64'd0;
                        mul_a_reg <= 64'(rec_reg.count);
                        mul_b_reg <= 47'(rec_reg.count);
                    end
                    else
                    begin
                        den_reg <= 65'(acc_step);
                        rem_reg <= '0;
                        cnt_reg <= '1;
                    end
                end
                else
                begin
                    acc_reg   <= acc_step;
                    mul_a_reg <= mul_a_reg << 1;
                    mul_b_reg <= mul_b_reg >> 1;
                end
            end
            B_DIV_VAR:
            begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    sx_reg   <= quo_step[31:0];
                    sr_reg   <= '0;
                    sbit_reg <= 32'h4000_0000;
                end
            end
            B_ROOT:
            begin
                sx_reg   <= sx_step;
                sr_reg   <= sr_step;
                sbit_reg <= sbit_reg >> 2;
            end
            B_HOLD:
            begin
                if (out_load)
                begin
                    seg_first  <= rec_reg.first;
                    seg_last   <= rec_reg.last;
                    seg_mean   <= mean_reg;
                    seg_spread <= sr_reg[15:0];
                    seg_low    <= rec_reg.low;
                    seg_high   <= rec_reg.high;
                    run_end    <= rec_reg.run_end;
                    set_done   <= rec_reg.done;
                end
            end
            default: ;
        endcase
    end

    assign empty = !out_valid_reg;

endmodule

// ----- sv/sss_checker.sv -----
`include "sample_stream_segmenter_stats_unit_macros.svh"

module sss_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [15:0] seg_mean,
    input logic signed [15:0] seg_low,
    input logic signed [15:0] seg_high
);

    `SSSU_ASSERT_NEXT(a_word_held, !empty && !pop, !empty)
    `SSSU_ASSERT_NOW(a_low_le_high, !empty, seg_low <= seg_high)
    `SSSU_ASSERT_NOW(a_mean_in_range, !empty, seg_mean >= seg_low && seg_mean <= seg_high)

endmodule

bind sample_stream_segmenter_stats_unit sss_checker u_sss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .seg_mean (seg_mean),
    .seg_low  (seg_low),
    .seg_high (seg_high)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

import sss_pkg::*;

typedef struct packed {
    logic [15:0]        first;
    logic [15:0]        last;
    logic signed [15:0] mean;
    logic [15:0]        spread;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic               run_end;
    logic               set_done;
} seg_word_t;

class seg_scoreboard;
    mode_t              mode;
    logic [16:0]        window;
    logic [15:0]        jump_lim;
    logic [15:0]        gap_lim;
    logic signed [15:0] marker;
    logic [15:0]        pos;
    logic [15:0]        start;
    logic signed [15:0] prior;
    int unsigned        count;
    longint             sum;
    longint unsigned    sqsum;
    logic signed [15:0] low;
    logic signed [15:0] high;
    seg_word_t          expected_q[$];
    int                 errors;

    function new();
        mode = MODE_WINDOW;
        window = 17'd100;
        jump_lim = 16'd3;
        gap_lim = 16'd100;
        marker = 16'sd0;
        pos = 0;
        prior = 0;
        errors = 0;
        clear_open();
    endfunction

    function void clear_open();
        count = 0;
        sum = 0;
        sqsum = 0;
        low = 0;
        high = 0;
        start = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [16:0] v);
        case (idx)
            REG_MODE:   mode = mode_t'(v[1:0]);
            REG_WINDOW: window = (v == 0) ? 17'd1 : v;
            REG_JUMP:   jump_lim = v[15:0];
            REG_GAP:    gap_lim = v[15:0];
            REG_MARKER: marker = v[15:0];
            default:    ;
        endcase
    endfunction

    function longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function seg_word_t close_segment(logic [15:0] last, bit done);
        seg_word_t w;
        longint unsigned n;
        longint          m;
        longint unsigned amag;
        longint unsigned num;
        longint unsigned sq;
        n = (count != 0) ? 64'(count) : 64'd1;
        m = sum / longint'(n);
        amag = (sum < 0) ? -sum : sum;
        num = n * sqsum;
        sq = amag * amag;
        w.first = start;
        w.last = last;
        w.mean = m[15:0];
        w.spread = 16'(floor_root(((num > sq) ? num - sq : 64'd0) / (n * n)));
        w.low = low;
        w.high = high;
        w.run_end = 0;
        w.set_done = done;
        clear_open();
        return w;
    endfunction

    function void note_input(logic signed [15:0] s, bit fin);
        seg_word_t    step_q[$];
        logic [15:0]  prev_idx;
        longint       d;
        longint       mag;
        bit           drop;
        prev_idx = pos - 16'd1;
        if ((mode == MODE_JUMP || mode == MODE_GAP) && count > 0)
        begin
            d = longint'(s) - longint'(prior);
            if (d < 0) d = -d;
            if (d > ((mode == MODE_JUMP) ? longint'(jump_lim) : longint'(gap_lim)))
                step_q.push_back(close_segment(prev_idx, 0));
        end
        drop = (mode == MODE_MARKER && s == marker && count > 0);
        if (drop)
            step_q.push_back(close_segment(prev_idx, fin));
        else
        begin
            if (count == 0)
            begin
                start = pos;
                low = s;
                high = s;
            end
            if (s < low) low = s;
            if (s > high) high = s;
            count++;
            sum += s;
            mag = (s < 0) ? -longint'(s) : longint'(s);
            sqsum += mag * mag;
            if (fin || count >= 65536 || (mode == MODE_WINDOW && count >= window))
                step_q.push_back(close_segment(pos, fin));
        end
        prior = s;
        if (step_q.size() > 0) step_q[step_q.size() - 1].run_end = 1;
        foreach (step_q[i]) expected_q.push_back(step_q[i]);
        if (fin)
        begin
            pos = 0;
            prior = 0;
            clear_open();
        end
        else
            pos++;
    endfunction

    function void check_word(seg_word_t got);
        seg_word_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10) $display("unexpected word %p", got);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want)
        begin
            errors++;
            if (errors <= 10) $display("word error: expected %p, got %p", want, got);
        end
    endfunction
endclass

module tb;
    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [15:0] sample;
    logic               final_sample;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [16:0]        cfg_data;
    logic               empty;
    logic               pop;
    seg_word_t          got;

    seg_scoreboard sb;
    int            burst_left;

    sample_stream_segmenter_stats_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample       (sample),
        .final_sample (final_sample),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .empty        (empty),
        .pop          (pop),
        .seg_first    (got.first),
        .seg_last     (got.last),
        .seg_mean     (got.mean),
        .seg_spread   (got.spread),
        .seg_low      (got.low),
        .seg_high     (got.high),
        .run_end      (got.run_end),
        .set_done     (got.set_done)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("sample_stream_segmenter_stats_unit: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && push && !full) sb.note_input(sample, final_sample);
        if (rst_n && pop && !empty) sb.check_word(got);
    end

    initial
    begin
        int stall_pct;
        pop = 0;
        forever
        begin
            stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 90);
            repeat ($urandom_range(50, 400))
            begin
                @(negedge clk);
                pop = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic send_word(logic signed [15:0] s, bit fin);
        push = 1;
        sample = s;
        final_sample = fin;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            push = 0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic drain();
        push = 0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [16:0] v);
        cfg_write = 1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_write = 0;
        sb.set_reg(idx, v);
    endtask

    function automatic logic [16:0] pick(int lo, int hi);
        case ($urandom_range(0, 5))
            0:       return 17'(lo);
            1:       return 17'(hi);
            default: return 17'($urandom_range(lo, (hi - lo > 40) ? lo + 40 : hi));
        endcase
    endfunction

    function automatic logic signed [15:0] next_sample(logic signed [15:0] prev);
        int v;
        int lim;
        case (sb.mode)
            MODE_JUMP, MODE_GAP:
            begin
                lim = (sb.mode == MODE_JUMP) ? int'(sb.jump_lim) : int'(sb.gap_lim);
                if ($urandom_range(0, 9) == 0) return 16'($urandom);
                v = int'(prev) + $urandom_range(0, 2 * lim + 2) - lim - 1;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return 16'(v);
            end
            MODE_MARKER:
                if ($urandom_range(0, 4) == 0) return sb.marker;
            default: ;
        endcase
        return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60) - 30);
    endfunction

    initial
    begin
        int                 items;
        int                 len;
        logic signed [15:0] s;
        sb = new();
        push = 0;
        sample = 0;
        final_sample = 0;
        cfg_write = 0;
        cfg_index = REG_MODE;
        cfg_data = 0;
        burst_left = 5;
        rst_n = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        write_reg(REG_WINDOW, 17'd3);
        send_word(-16'sd32768, 0);
        send_word(16'sd32767, 0);
        send_word(16'sd0, 0);
        send_word(16'sd5, 0);
        send_word(-16'sd7, 1);
        drain();
        write_reg(REG_WINDOW, 17'd0);
        send_word(16'sd9, 0);
        drain();
        write_reg(REG_MODE, 17'(MODE_JUMP));
        write_reg(REG_JUMP, 17'd0);
        send_word(16'sd1, 0);
        send_word(16'sd1, 0);
        send_word(16'sd2, 0);
        send_word(16'sd2, 1);
        drain();
        write_reg(REG_MODE, 17'(MODE_GAP));
        write_reg(REG_GAP, 17'd65535);
        send_word(-16'sd32768, 0);
        send_word(16'sd32767, 0);
        send_word(-16'sd32768, 1);
        drain();
        write_reg(REG_MODE, 17'(MODE_MARKER));
        write_reg(REG_MARKER, 17'h08000);
        send_word(-16'sd32768, 0);
        send_word(16'sd4, 0);
        send_word(-16'sd32768, 0);
        send_word(16'sd6, 0);
        send_word(-16'sd32768, 1);
        send_word(-16'sd32768, 1);
        drain();

        items = 0;
        while (items < 750)
        begin
            write_reg(REG_MODE, 17'(mode_t'($urandom_range(0, 3))));
            write_reg(REG_WINDOW, ($urandom_range(0, 9) == 0) ? 17'h10000 : pick(0, 12));
            write_reg(REG_JUMP, ($urandom_range(0, 7) == 0) ? 17'd65535 : pick(0, 200));
            write_reg(REG_GAP, ($urandom_range(0, 7) == 0) ? 17'd65535 : pick(0, 2000));
            write_reg(REG_MARKER, ($urandom_range(0, 1) == 0) ? 17'(pick(0, 5))
                                                             : 17'($urandom));
            repeat ($urandom_range(2, 6))
            begin
                len = $urandom_range(1, 25);
                s = next_sample(0);
                for (int k = 0; k < len; k++)
                begin
                    send_word(s, (k == len - 1) && ($urandom_range(0, 5) != 0));
                    s = next_sample(s);
                    items++;
                end
            end
            drain();
        end

        drain();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("sample_stream_segmenter_stats_unit: match");
        else
            $display("sample_stream_segmenter_stats_unit: mismatch");
        $finish;
    end
endmodule
